// ----- sv/frp_pkg.sv -----
package frp_pkg;

    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_NL = 8'h0A;

    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_UPPER_LO = 8'h41;
    localparam logic [7:0] CH_UPPER_HI = 8'h5A;
    localparam logic [7:0] CH_LOWER_LO = 8'h61;
    localparam logic [7:0] CH_LOWER_HI = 8'h7A;

    localparam int APB_ADDR_W = 3;
    localparam logic REG_MIN_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        KIND_NAME = 2'd0,
        KIND_BASE = 2'd1,
        KIND_END  = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic        in_header;
        logic [15:0] name_count;
        logic [31:0] base_count;
        logic [15:0] record_count;
    } frp_state_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  char_value;
        logic [15:0] record_index;
        logic [15:0] name_length;
        logic [31:0] base_length;
        logic        too_short;
    } frp_item_t;

    typedef struct packed {
        logic      valid;
        frp_item_t item;
    } frp_result_t;

endpackage

// ----- sv/frp_in_if.sv -----
interface frp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- sv/frp_out_if.sv -----
interface frp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  char_value;
    logic [15:0] record_index;
    logic [15:0] name_length;
    logic [31:0] base_length;
    logic        too_short;

    modport source (
        output valid, output item_kind, output char_value, output record_index,
        output name_length, output base_length, output too_short, input ready
    );
    modport sink (
        input valid, input item_kind, input char_value, input record_index,
        input name_length, input base_length, input too_short, output ready
    );
endinterface

// ----- sv/fasta_record_parser.sv -----
// An accepted byte is held in the input register, then its result is registered in the
// result register once the output register is free (input reg, result reg).
// Throughput: one byte per cycle; a stall on the output holds the input stage.
// Bytes that produce no result retire from the input stage without using the output register.
// Reset (rst_n low, async): header mode, all counts zero, min_length zero, both stages empty.
module fasta_record_parser
    import frp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    frp_in_if.sink                in_ch,
    frp_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [31:0] min_length_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eoi_reg;

    frp_state_t  state_reg;
    frp_state_t  state_next;
    frp_result_t step_res;

    logic        out_valid_reg;
    frp_item_t   out_item_reg;

    logic        out_free;
    logic        s1_retire;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_LENGTH);
    assign prdata    = (paddr[2] == REG_MIN_LENGTH) ? min_length_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            min_length_reg <= pwdata;
        end
    end

    frp_step u_step (
        .state        (state_reg),
        .in_byte      (s1_byte_reg),
        .end_of_input (s1_eoi_reg),
        .min_length   (min_length_reg),
        .result       (step_res),
        .state_next   (state_next)
    );

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_retire   = s1_valid_reg && (!step_res.valid || out_free);
    assign in_ch.ready = !s1_valid_reg || s1_retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_byte_reg <= in_ch.in_byte;
            s1_eoi_reg  <= in_ch.end_of_input;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.in_header    <= 1'b1;
            state_reg.name_count   <= '0;
            state_reg.base_count   <= '0;
            state_reg.record_count <= '0;
        end
        else if (s1_retire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && step_res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && step_res.valid)
        begin
            out_item_reg <= step_res.item;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.item_kind    = out_item_reg.kind;
    assign out_ch.char_value   = out_item_reg.char_value;
    assign out_ch.record_index = out_item_reg.record_index;
    assign out_ch.name_length  = out_item_reg.name_length;
    assign out_ch.base_length  = out_item_reg.base_length;
    assign out_ch.too_short    = out_item_reg.too_short;

    // end of input always closes the record and clears the counts
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_retire && s1_eoi_reg |=>
            state_reg.in_header && state_reg.name_count == '0 && state_reg.base_count == '0)
    else $error("record not closed on end of input");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> state_reg.record_count >= $past(state_reg.record_count))
    else $error("record count went backwards");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_retire && !s1_eoi_reg && !state_reg.in_header && s1_byte_reg != CH_GT
            |=> $stable(state_reg.name_count))
    else $error("name count changed in sequence mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.kind != KIND_END |->
            out_item_reg.name_length == '0 && out_item_reg.base_length == '0
            && !out_item_reg.too_short)
    else $error("character transfer carries summary fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.kind == KIND_END |-> out_item_reg.char_value == '0)
    else $error("summary transfer carries a character");

endmodule

// ----- sv/frp_step.sv -----
module frp_step
    import frp_pkg::*;
(
    input  frp_state_t  state,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    input  logic [31:0] min_length,
    output frp_result_t result,
    output frp_state_t  state_next
);

    logic printable;
    logic upper;
    logic lower;

    assign printable = (in_byte >= CH_PRINT_LO) && (in_byte <= CH_PRINT_HI);
    assign upper     = (in_byte >= CH_UPPER_LO) && (in_byte <= CH_UPPER_HI);
    assign lower     = (in_byte >= CH_LOWER_LO) && (in_byte <= CH_LOWER_HI);

    always_comb
    begin
        state_next               = state;
        result                   = '0;
        result.item.kind         = KIND_NAME;
        result.item.record_index = state.record_count;

        if (end_of_input || (!state.in_header && in_byte == CH_GT))
        begin
            result.valid            = 1'b1;
            result.item.kind        = KIND_END;
            result.item.name_length = state.name_count;
            result.item.base_length = state.base_count;
            result.item.too_short   = (state.base_count <= min_length);
            state_next.in_header    = 1'b1;
            state_next.name_count   = '0;
            state_next.base_count   = '0;
            if (state.record_count != '1)
            begin
                state_next.record_count = state.record_count + 16'd1;
            end
        end
        else if (state.in_header)
        begin
            if (in_byte == CH_NL)
            begin
                state_next.in_header = 1'b0;
            end
            else if (printable && in_byte != CH_GT)
            begin
                result.valid           = 1'b1;
                result.item.kind       = KIND_NAME;
                result.item.char_value = in_byte;
                if (state.name_count != '1)
                begin
                    state_next.name_count = state.name_count + 16'd1;
                end
            end
        end
        else if (upper || lower)
        begin
            result.valid           = 1'b1;
            result.item.kind       = KIND_BASE;
            result.item.char_value = lower ? CH_N : in_byte;
            if (state.base_count != '1)
            begin
                state_next.base_count = state.base_count + 32'd1;
            end
        end
    end

endmodule

// ----- tb/sv/tb_fasta_record_parser.sv -----
`timescale 1ns / 100ps

module tb_fasta_record_parser;
    import frp_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ITEMS = 1550;
    localparam logic [APB_ADDR_W-1:0] MIN_LEN_ADDR = (APB_ADDR_W'(REG_MIN_LENGTH)) << 2;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    frp_in_if  in_ch ();
    frp_out_if out_ch ();

    fasta_record_parser u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser state as predicted
    logic        hdr_mode;
    logic [15:0] name_cnt;
    logic [31:0] base_cnt;
    logic [15:0] rec_cnt;
    logic [31:0] min_len_cfg;

    frp_item_t parsed_q [$];

    int n_sent;
    int n_results;
    int n_summaries;
    int n_cfg_writes;
    int n_fail;
    bit idle_en;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_fasta_record_parser failed");
        $finish;
    end

    function automatic void note_fail(input string msg);
        n_fail++;
        if (n_fail <= MAX_SHOWN)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic eoi,
                                      output frp_item_t res);
        res = '0;
        res.record_index = rec_cnt;
        if (eoi || (!hdr_mode && b == CH_GT))
        begin
            res.kind        = KIND_END;
            res.name_length = name_cnt;
            res.base_length = base_cnt;
            res.too_short   = (base_cnt <= min_len_cfg);
            if (rec_cnt != 16'hFFFF)
                rec_cnt++;
            name_cnt = '0;
            base_cnt = '0;
            hdr_mode = 1'b1;
            return 1'b1;
        end
        if (hdr_mode)
        begin
            if (b == CH_NL)
            begin
                hdr_mode = 1'b0;
                return 1'b0;
            end
            if (b >= CH_PRINT_LO && b <= CH_PRINT_HI && b != CH_GT)
            begin
                res.kind       = KIND_NAME;
                res.char_value = b;
                if (name_cnt != 16'hFFFF)
                    name_cnt++;
                return 1'b1;
            end
            return 1'b0;
        end
        if ((b >= CH_LOWER_LO && b <= CH_LOWER_HI) || (b >= CH_UPPER_LO && b <= CH_UPPER_HI))
        begin
            res.kind       = KIND_BASE;
            res.char_value = (b >= CH_LOWER_LO) ? CH_N : b;
            if (base_cnt != 32'hFFFF_FFFF)
                base_cnt++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [7:0] print_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        while (b == CH_GT);
        return b;
    endfunction

    function automatic logic [7:0] base_char();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(CH_UPPER_LO + r) : 8'(CH_LOWER_LO + (r - 26));
    endfunction

    // one input transfer, then an optional gap
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        frp_item_t res;
        int        gap;
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (parse_byte(b, eoi, res))
            parsed_q.push_back(res);
        n_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.in_byte      <= 8'($urandom);
            in_ch.end_of_input <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_record(input int name_len, input int n_bases, input bit noisy);
        send_byte(CH_GT, 1'b0);
        for (int i = 0; i < name_len; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_byte(8'($urandom), 1'b0);
            else
                send_byte(print_char(), 1'b0);
        end
        send_byte(CH_NL, 1'b0);
        for (int i = 0; i < n_bases; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_byte(CH_NL, 1'b0);
            if (noisy && $urandom_range(0, 19) == 0)
                send_byte(8'($urandom), 1'b0);
            send_byte(base_char(), 1'b0);
        end
    endtask

    task automatic drain_idle();
        in_ch.valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        // bytes with no result may still sit in the input stage
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == MIN_LEN_ADDR)
            min_len_cfg = data;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_min_length(input logic [31:0] value);
        logic [31:0] rd;
        drain_idle();
        apb_write(MIN_LEN_ADDR, value);
        n_cfg_writes++;
        apb_read(MIN_LEN_ADDR, rd);
        if (rd !== value)
            note_fail($sformatf("min_length readback exp %08h got %08h", value, rd));
    endtask

    task automatic check_result();
        frp_item_t want;
        n_results++;
        if (parsed_q.size() == 0)
        begin
            note_fail($sformatf("unexpected result kind %0d char %02h rec %0d",
                                out_ch.item_kind, out_ch.char_value, out_ch.record_index));
            return;
        end
        want = parsed_q.pop_front();
        if (want.kind == KIND_END)
            n_summaries++;
        if (out_ch.item_kind !== want.kind || out_ch.char_value !== want.char_value ||
            out_ch.record_index !== want.record_index ||
            out_ch.name_length !== want.name_length ||
            out_ch.base_length !== want.base_length || out_ch.too_short !== want.too_short)
            note_fail($sformatf({"mismatch exp %s ch %02h rec %0d nlen %0d blen %0d short %0b",
                                 " / got kind %0d ch %02h rec %0d nlen %0d blen %0d short %0b"},
                                want.kind.name(), want.char_value, want.record_index,
                                want.name_length, want.base_length, want.too_short,
                                out_ch.item_kind, out_ch.char_value, out_ch.record_index,
                                out_ch.name_length, out_ch.base_length, out_ch.too_short));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result();
    end

    // output back-pressure: runs of ready/not-ready
    initial
    begin
        int run_left;
        bit level;
        run_left = 0;
        level    = 1'b1;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                if (!idle_en)
                begin
                    level    = 1'b1;
                    run_left = 1;
                end
                else
                begin
                    level    = ($urandom_range(0, 99) < 70);
                    run_left = (level || $urandom_range(0, 9) != 0) ? $urandom_range(1, 6)
                                                                    : $urandom_range(10, 40);
                end
            end
            out_ch.ready <= level;
            run_left--;
        end
    end

    task automatic test_directed();
        logic [31:0] rd;
        idle_en = 1'b1;
        apb_read(MIN_LEN_ADDR, rd);
        if (rd !== 32'd0)
            note_fail($sformatf("min_length after reset exp 0 got %08h", rd));
        // '>' and control bytes are dropped in a header
        send_byte(CH_GT, 1'b0);
        send_text("s");
        send_byte(8'h1F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NL, 1'b0);
        // soft-masked bases, letter range edges, newline inside sequence
        send_text("AcGt\nZaz@[");
        send_byte(8'h60, 1'b0);
        send_text("{");
        send_byte(CH_GT, 1'b0);
        send_byte(CH_PRINT_LO, 1'b0);
        send_byte(CH_PRINT_HI, 1'b0);
        send_byte(CH_NL, 1'b0);
        // end of input, then a repeated one on an empty record
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        // end of input inside a header
        send_text("x");
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_min_length();
        logic [31:0] th [5];
        th = '{32'hFFFF_FFFF, 32'd0, 32'd5, 32'h8000_0000, $urandom_range(1, 30)};
        foreach (th[k])
        begin
            set_min_length(th[k]);
            idle_en = (k % 2 == 0);
            if (th[k] <= 64)
            begin
                for (int d = -1; d <= 1; d++)
                begin
                    if (int'(th[k]) + d >= 0)
                        send_record(3, int'(th[k]) + d, 1'b0);
                end
            end
            send_record(2, 0, 1'b0);
            send_record(1, 1, 1'b0);
            send_byte(8'h00, 1'b1);
        end
    endtask

    task automatic test_random_stream();
        int stop_at;
        int next_cfg;
        int r;
        logic [31:0] th;
        stop_at  = n_sent + RANDOM_ITEMS;
        next_cfg = n_sent + 450;
        idle_en  = 1'b1;
        while (n_sent < stop_at)
        begin
            if (n_sent >= next_cfg)
            begin
                case ($urandom_range(0, 3))
                    0:       th = 32'd0;
                    1:       th = 32'hFFFF_FFFF;
                    2:       th = $urandom_range(0, 60);
                    default: th = $urandom;
                endcase
                set_min_length(th);
                idle_en  = ($urandom_range(0, 3) != 0);
                next_cfg = n_sent + 450;
            end
            r = $urandom_range(0, 99);
            if (r < 80)
                send_record(($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                        : $urandom_range(0, 12),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                        : $urandom_range(0, 40),
                            r < 20);
            else if (r < 88)
                send_byte(8'($urandom), 1'b1);
            else
                repeat ($urandom_range(1, 20))
                    send_byte(8'($urandom), $urandom_range(0, 19) == 0);
        end
        send_byte(8'($urandom), 1'b1);
    endtask

    initial
    begin
        int waited;
        hdr_mode    = 1'b1;
        name_cnt    = '0;
        base_cnt    = '0;
        rec_cnt     = '0;
        min_len_cfg = '0;
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= 8'h00;
        in_ch.end_of_input <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_min_length();
        test_random_stream();

        in_ch.valid <= 1'b0;
        waited = 0;
        while (parsed_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (parsed_q.size() != 0)
            note_fail($sformatf("%0d results never arrived", parsed_q.size()));

        $display("covered %0d input transfers, %0d results, %0d record summaries",
                 n_sent, n_results, n_summaries);
        $display("%0d min_length settings incl. 0 and all-ones, with random stalls on both sides",
                 n_cfg_writes);
        if (n_fail == 0)
            $display("tb_fasta_record_parser passed");
        else
            $display("tb_fasta_record_parser failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/frp_pkg.sv
sv/frp_in_if.sv
sv/frp_out_if.sv
sv/frp_step.sv
sv/fasta_record_parser.sv
tb/sv/tb_fasta_record_parser.sv
